// ----- src/trm_pkg.sv -----
// Package with the shared constants, types and codes of the register machine core.
`timescale 1ns / 1ps
package trm_pkg;

	localparam int MEM_DEPTH = 4096;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int REG_COUNT = 8;
	localparam int REG_AW    = $clog2(REG_COUNT);

	typedef logic [MEM_AW-1:0] maddr_t;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_EXEC  = 2'd2;

	localparam logic [1:0] STAT_POS  = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_NEG  = 2'd2;

	localparam logic CFG_START_PC = 1'b0;
	localparam logic CFG_START_SP = 1'b1;

	localparam logic [31:0] OPC_LOAD  = 32'd1;
	localparam logic [31:0] OPC_STORE = 32'd2;
	localparam logic [31:0] OPC_READ  = 32'd3;
	localparam logic [31:0] OPC_WRITE = 32'd4;
	localparam logic [31:0] OPC_COPY  = 32'd5;
	localparam logic [31:0] OPC_ADD   = 32'd6;
	localparam logic [31:0] OPC_SUB   = 32'd7;
	localparam logic [31:0] OPC_AND   = 32'd8;
	localparam logic [31:0] OPC_OR    = 32'd9;
	localparam logic [31:0] OPC_XOR   = 32'd10;
	localparam logic [31:0] OPC_NOT   = 32'd11;
	localparam logic [31:0] OPC_JMP   = 32'd12;
	localparam logic [31:0] OPC_JZ    = 32'd13;
	localparam logic [31:0] OPC_JNZ   = 32'd14;
	localparam logic [31:0] OPC_JN    = 32'd15;
	localparam logic [31:0] OPC_JP    = 32'd16;
	localparam logic [31:0] OPC_PUSH  = 32'd17;
	localparam logic [31:0] OPC_POP   = 32'd18;
	localparam logic [31:0] OPC_CALL  = 32'd19;
	localparam logic [31:0] OPC_RET   = 32'd20;
	localparam logic [31:0] OPC_HALT  = 32'd21;

	// Commands from the controller: one strobe per phase of an item.
	typedef struct packed {
		logic accept;
		logic op;
		logic w1;
		logic w2;
		logic exec;
		logic data;
		logic fin;
	} trm_cmd_t;

	// Status back to the controller.
	typedef struct packed {
		logic run;
		logic needs_data;
		logic out_busy;
	} trm_stat_t;

endpackage

// ----- src/trm_if.sv -----
// Interfaces for the request and response channels.
`timescale 1ns / 1ps
interface trm_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [11:0]        address;
	logic signed [31:0] data_word;

	modport source (output valid, kind, address, data_word, input ready);
	modport sink (input valid, kind, address, data_word, output ready);
endinterface

interface trm_rsp_if;
	logic               valid;
	logic               ready;
	logic               write_valid;
	logic signed [31:0] write_value;
	logic               read_taken;
	logic               halted;
	logic               bad_opcode;
	logic [1:0]         status_word;
	logic [11:0]        pc_now;
	logic [7:0]         opcode_done;

	modport source (output valid, write_valid, write_value, read_taken, halted, bad_opcode,
		status_word, pc_now, opcode_done, input ready);
	modport sink (input valid, write_valid, write_value, read_taken, halted, bad_opcode,
		status_word, pc_now, opcode_done, output ready);
endinterface

// ----- src/trm_ctrl.sv -----
// Controller state machine that sequences fetch, execute and result phases.
`timescale 1ns / 1ps
module trm_ctrl import trm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  trm_stat_t stat,
	output trm_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_OP   = 7'b0000010,
		S_W1   = 7'b0000100,
		S_W2   = 7'b0001000,
		S_EXEC = 7'b0010000,
		S_DATA = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == S_IDLE) && req_valid;
		cmd.op     = (state_q == S_OP);
		cmd.w1     = (state_q == S_W1);
		cmd.w2     = (state_q == S_W2);
		cmd.exec   = (state_q == S_EXEC);
		cmd.data   = (state_q == S_DATA);
		cmd.fin    = (state_q == S_FIN) && !stat.out_busy;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (req_valid) state_d = S_OP;
			S_OP:   state_d = stat.run ? S_W1 : S_FIN;
			S_W1:   state_d = S_W2;
			S_W2:   state_d = S_EXEC;
			S_EXEC: state_d = stat.needs_data ? S_DATA : S_FIN;
			S_DATA: state_d = S_FIN;
			S_FIN:  if (!stat.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A result is never loaded while the previous one still waits.
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !stat.out_busy) else $error("result loaded over a pending one");
	// Data phase only follows execute.
	a_data_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DATA) |-> $past(state_q == S_EXEC)) else $error("bad data phase");
	// An accepted item always starts with the opcode phase.
	a_accept_op: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == S_OP)) else $error("accept not followed by op phase");

endmodule

// ----- src/trm_dp.sv -----
// Datapath: word memory, register file, PC, SP, flags and result register.
`timescale 1ns / 1ps
module trm_dp import trm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [11:0]        cfg_wdata,
	input  logic [1:0]         req_kind,
	input  logic [11:0]        req_address,
	input  logic signed [31:0] req_data_word,
	input  trm_cmd_t           cmd,
	output trm_stat_t          stat,
	input  logic               rsp_ready,
	output logic               rsp_valid,
	output logic               rsp_write_valid,
	output logic signed [31:0] rsp_write_value,
	output logic               rsp_read_taken,
	output logic               rsp_halted,
	output logic               rsp_bad_opcode,
	output logic [1:0]         rsp_status_word,
	output logic [11:0]        rsp_pc_now,
	output logic [7:0]         rsp_opcode_done
);

	logic [11:0] start_pc_q, start_sp_q;
	logic [1:0]  kind_q;
	logic [11:0] addr_q;
	logic [31:0] data_q;
	maddr_t      pc_q, sp_q;
	logic [1:0]  status_q;
	logic        halt_q, err_q;
	logic [31:0] regs_q [REG_COUNT];
	logic [31:0] op_q, w1_q, a_q;
	logic        wv_q, rt_q;
	logic [31:0] wval_q;
	logic [7:0]  done_q;

	logic        out_valid_q;
	logic        out_wv_q, out_rt_q, out_halt_q, out_err_q;
	logic [31:0] out_wval_q;
	logic [1:0]  out_status_q;
	logic [11:0] out_pc_q;
	logic [7:0]  out_done_q;

	logic [31:0] mem_q [MEM_DEPTH];
	logic [31:0] mem_rd_q;
	maddr_t      mem_addr;
	logic        mem_we;
	logic [31:0] mem_wd;

	logic [REG_AW-1:0] ra, rsel;
	logic [31:0]       reg_rd, alu_res;
	maddr_t            pc1, pc2, pc3, ld_addr, sp_dec, sp_inc, jmp_tgt, call_tgt;
	logic              op_bad, take;

	function automatic logic [1:0] status_of(input logic [31:0] v);
		if (v == '0) return STAT_ZERO;
		if (v[31]) return STAT_NEG;
		return STAT_POS;
	endfunction

	assign ra       = w1_q[REG_AW-1:0];
	// The memory read word holds the first operand in the w2 phase and the second in execute.
	assign rsel     = mem_rd_q[REG_AW-1:0];
	assign reg_rd   = regs_q[rsel];
	assign pc1      = pc_q + maddr_t'(1);
	assign pc2      = pc_q + maddr_t'(2);
	assign pc3      = pc_q + maddr_t'(3);
	assign ld_addr  = pc3 + mem_rd_q[MEM_AW-1:0];
	assign jmp_tgt  = pc2 + w1_q[MEM_AW-1:0];
	assign call_tgt = jmp_tgt;
	assign sp_dec   = sp_q - maddr_t'(1);
	assign sp_inc   = sp_q + maddr_t'(1);
	assign op_bad   = (op_q == '0) || (op_q > OPC_HALT);

	always_comb begin
		case (op_q)
			OPC_ADD: alu_res = a_q + reg_rd;
			OPC_SUB: alu_res = a_q - reg_rd;
			OPC_AND: alu_res = a_q & reg_rd;
			OPC_OR:  alu_res = a_q | reg_rd;
			OPC_XOR: alu_res = a_q ^ reg_rd;
			default: alu_res = ~a_q;
		endcase
	end

	always_comb begin
		case (op_q)
			OPC_JZ:  take = (status_q == STAT_ZERO);
			OPC_JNZ: take = (status_q != STAT_ZERO);
			OPC_JN:  take = (status_q == STAT_NEG);
			OPC_JP:  take = (status_q == STAT_POS);
			default: take = 1'b1;
		endcase
	end

	always_comb begin
		mem_addr = pc_q;
		mem_we   = 1'b0;
		mem_wd   = a_q;
		if (cmd.op && kind_q == KIND_WRITE) begin
			mem_addr = maddr_t'(addr_q);
			mem_we   = 1'b1;
			mem_wd   = data_q;
		end else if (cmd.w1) begin
			mem_addr = pc1;
		end else if (cmd.w2) begin
			mem_addr = pc2;
		end else if (cmd.exec) begin
			case (op_q)
				OPC_LOAD: mem_addr = ld_addr;
				OPC_STORE: begin
					mem_addr = ld_addr;
					mem_we   = 1'b1;
				end
				OPC_PUSH: begin
					mem_addr = sp_dec;
					mem_we   = 1'b1;
				end
				OPC_CALL: begin
					mem_addr = sp_dec;
					mem_we   = 1'b1;
					mem_wd   = 32'(pc2);
				end
				OPC_POP, OPC_RET: mem_addr = sp_q;
				default: mem_addr = pc_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wd;
		end
		mem_rd_q <= mem_q[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= req_kind;
			addr_q <= req_address;
			data_q <= req_data_word;
		end
		if (cmd.w1) begin
			op_q <= mem_rd_q;
		end
		if (cmd.w2) begin
			w1_q <= mem_rd_q;
			a_q  <= reg_rd;
		end
		if (cmd.fin) begin
			out_wv_q     <= wv_q;
			out_wval_q   <= wval_q;
			out_rt_q     <= rt_q;
			out_halt_q   <= halt_q;
			out_err_q    <= err_q;
			out_status_q <= status_q;
			out_pc_q     <= 12'(pc_q);
			out_done_q   <= done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q  <= '0;
			start_sp_q  <= '0;
			pc_q        <= '0;
			sp_q        <= '0;
			status_q    <= STAT_POS;
			halt_q      <= 1'b1;
			err_q       <= 1'b0;
			wv_q        <= 1'b0;
			wval_q      <= '0;
			rt_q        <= 1'b0;
			done_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < REG_COUNT; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_PC: start_pc_q <= cfg_wdata;
					CFG_START_SP: start_sp_q <= cfg_wdata;
					default: start_pc_q <= start_pc_q;
				endcase
			end
			if (cmd.accept) begin
				wv_q   <= 1'b0;
				wval_q <= '0;
				rt_q   <= 1'b0;
				done_q <= '0;
			end
			if (cmd.op && kind_q == KIND_START) begin
				pc_q     <= maddr_t'(start_pc_q);
				sp_q     <= maddr_t'(start_sp_q);
				status_q <= STAT_POS;
				halt_q   <= 1'b0;
				err_q    <= 1'b0;
			end
			if (cmd.exec) begin
				if (op_bad) begin
					halt_q <= 1'b1;
					err_q  <= 1'b1;
				end else begin
					done_q <= op_q[7:0];
					case (op_q)
						OPC_LOAD, OPC_STORE: pc_q <= pc3;
						OPC_READ: begin
							pc_q       <= pc2;
							regs_q[ra] <= data_q;
							rt_q       <= 1'b1;
						end
						OPC_WRITE: begin
							pc_q   <= pc2;
							wv_q   <= 1'b1;
							wval_q <= a_q;
						end
						OPC_COPY: begin
							pc_q       <= pc3;
							regs_q[ra] <= reg_rd;
						end
						OPC_ADD, OPC_SUB, OPC_AND, OPC_OR, OPC_XOR, OPC_NOT: begin
							pc_q       <= (op_q == OPC_NOT) ? pc2 : pc3;
							regs_q[ra] <= alu_res;
							status_q   <= status_of(alu_res);
						end
						OPC_JMP, OPC_JZ, OPC_JNZ, OPC_JN, OPC_JP: begin
							pc_q <= take ? jmp_tgt : pc2;
						end
						OPC_PUSH: begin
							pc_q <= pc2;
							sp_q <= sp_dec;
						end
						OPC_POP: begin
							pc_q <= pc2;
							sp_q <= sp_inc;
						end
						OPC_CALL: begin
							pc_q <= call_tgt;
							sp_q <= sp_dec;
						end
						OPC_RET: sp_q <= sp_inc;
						default: halt_q <= 1'b1;
					endcase
				end
			end
			if (cmd.data) begin
				case (op_q)
					OPC_RET: pc_q <= mem_rd_q[MEM_AW-1:0];
					default: regs_q[ra] <= mem_rd_q;
				endcase
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.run        = (kind_q == KIND_EXEC) && !halt_q;
	assign stat.needs_data = (op_q == OPC_LOAD) || (op_q == OPC_POP) || (op_q == OPC_RET);
	assign stat.out_busy   = out_valid_q && !rsp_ready;

	assign rsp_valid       = out_valid_q;
	assign rsp_write_valid = out_wv_q;
	assign rsp_write_value = out_wval_q;
	assign rsp_read_taken  = out_rt_q;
	assign rsp_halted      = out_halt_q;
	assign rsp_bad_opcode  = out_err_q;
	assign rsp_status_word = out_status_q;
	assign rsp_pc_now      = out_pc_q;
	assign rsp_opcode_done = out_done_q;

	// The error flag never stands without the halt flag.
	a_err_halt: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> halt_q) else $error("error flag without halt");
	// An unknown opcode halts the machine with the error flag.
	a_bad_op: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_bad) |=> (halt_q && err_q)) else $error("bad opcode not trapped");
	// Memory is written only in the opcode or execute phase.
	a_mem_we: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (cmd.op || cmd.exec)) else $error("stray memory write");

endmodule

// ----- src/toy_register_machine_core_top.sv -----
// Top level of the register machine core: controller plus datapath.
`timescale 1ns / 1ps
//  Channel | Dir | Handshake     | Contents
//  req     | in  | valid/ready   | kind, address, data_word
//  rsp     | out | valid/ready   | write_valid .. opcode_done, one per request
//  cfg     | in  | cfg_we        | start_pc (index 0), start_sp (index 1)
//
// A memory write, start or ignored request has only the opcode and result phases.
// An instruction adds w1, w2 and execute, and a data phase for LOAD, POP and RET.
// The single memory port fetches the opcode and two operand words one per cycle.
// A new request transfers as soon as the controller is idle, even while the last
// result waits; that result holds until the sink takes it.
// Reset clears registers, PC, SP and status and leaves the machine halted; the word
// memory is not cleared and reads as unknown until written.
module toy_register_machine_core_top import trm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_wdata,
	trm_req_if.sink     req,
	trm_rsp_if.source   rsp
);

	trm_cmd_t  cmd;
	trm_stat_t stat;

	// Sequencing of the phases of each transfer.
	trm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage, arithmetic and the output register.
	trm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.req_kind        (req.kind),
		.req_address     (req.address),
		.req_data_word   (req.data_word),
		.cmd             (cmd),
		.stat            (stat),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_write_valid (rsp.write_valid),
		.rsp_write_value (rsp.write_value),
		.rsp_read_taken  (rsp.read_taken),
		.rsp_halted      (rsp.halted),
		.rsp_bad_opcode  (rsp.bad_opcode),
		.rsp_status_word (rsp.status_word),
		.rsp_pc_now      (rsp.pc_now),
		.rsp_opcode_done (rsp.opcode_done)
	);

endmodule
